[hw/rtl/ogru_pkg.sv]
// Shared types and constants of the occupancy grid ray update block.
`default_nettype none
package ogru_pkg;

	// Field widths.
	localparam int COORD_W    = 11;
	localparam int WALK_W     = 12;
	localparam int ERR_W      = 14;
	localparam int TRACED_W   = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OCCUPIED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PERCENT  = 3'd5;

	// Cell values reported in counting mode.
	localparam logic [7:0] VALUE_UNKNOWN  = 8'd50;
	localparam logic [7:0] VALUE_OCCUPIED = 8'd100;
	localparam logic [7:0] VALUE_FREE     = 8'd0;

	// Item kinds and mapping modes.
	localparam logic KIND_RAY   = 1'b0;
	localparam logic KIND_READ  = 1'b1;
	localparam logic MODE_LOG   = 1'b0;
	localparam logic MODE_COUNT = 1'b1;

	// Memory operations carried down the access pipeline.
	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_NONE = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE = 2'd1;
	localparam logic [OP_W-1:0] OP_HIT  = 2'd2;
	localparam logic [OP_W-1:0] OP_READ = 2'd3;

	typedef struct packed {
		logic       mode;
		logic [7:0] free_step;
		logic [7:0] occupied_step;
		logic [7:0] value_min;
		logic [7:0] value_max;
		logic [6:0] occupied_percent;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		mode: 1'b0, free_step: 8'd1, occupied_step: 8'd2,
		value_min: 8'd0, value_max: 8'd100, occupied_percent: 7'd35
	};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic setup;
		logic step;
		logic issue_hit;
		logic issue_read;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic end_off;
		logic is_read;
		logic walk_done;
		logic pipe_busy;
	} sts_t;

endpackage
`default_nettype wire

[hw/rtl/ogru_if.sv]
// Valid and ready channels for request and result items.
`default_nettype none
interface ogru_req_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   kind;
	logic signed [ogru_pkg::COORD_W-1:0]    start_x;
	logic signed [ogru_pkg::COORD_W-1:0]    start_y;
	logic signed [ogru_pkg::COORD_W-1:0]    end_x;
	logic signed [ogru_pkg::COORD_W-1:0]    end_y;

	modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
	modport sink (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

interface ogru_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              status;
	logic [7:0]                        cell_value;
	logic [ogru_pkg::TRACED_W-1:0]     cells_traced;

	modport source (output valid, status, cell_value, cells_traced, input ready);
	modport sink (input valid, status, cell_value, cells_traced, output ready);
endinterface
`default_nettype wire

[hw/rtl/ogru_ctrl.sv]
// Controller state machine sequencing clear, setup, tracing and result hand-off.
`default_nettype none
module ogru_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	input  wire ogru_pkg::sts_t sts,
	output ogru_pkg::cmd_t      cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;
	localparam logic [2:0] ST_TRACE = 3'd3;
	localparam logic [2:0] ST_HIT   = 3'd4;
	localparam logic [2:0] ST_RDISS = 3'd5;
	localparam logic [2:0] ST_WAIT  = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				if (sts.end_off) state_d = ST_FIN;
				else if (sts.is_read) state_d = ST_RDISS;
				else state_d = ST_TRACE;
			end
			ST_TRACE: begin
				if (sts.walk_done) state_d = ST_HIT;
				else cmd.step = 1'b1;
			end
			ST_HIT: begin
				cmd.issue_hit = 1'b1;
				state_d       = ST_WAIT;
			end
			ST_RDISS: begin
				cmd.issue_read = 1'b1;
				state_d        = ST_WAIT;
			end
			ST_WAIT: begin
				if (!sts.pipe_busy) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !req_ready)
		else $error("request taken during clearing pass");
	a_pipe_idle_at_edges: assert property (@(posedge clk) disable iff (!arst_n)
		sts.pipe_busy |-> !(state_q == ST_IDLE || state_q == ST_FIN))
		else $error("memory pipeline busy outside an item");
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside finish state");
`endif

endmodule
`default_nettype wire

[hw/rtl/ogru_dp.sv]
// Datapath: line walker, grid memories, cell update and read evaluation.
`default_nettype none
module ogru_dp #(
	parameter int MAP_WIDTH  = 256,
	parameter int MAP_HEIGHT = 256,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire ogru_pkg::cfg_t                         cfg,
	input  wire ogru_pkg::cmd_t                         cmd,
	output ogru_pkg::sts_t                              sts,
	input  wire logic                                   kind,
	input  wire logic signed [ogru_pkg::COORD_W-1:0]    start_x,
	input  wire logic signed [ogru_pkg::COORD_W-1:0]    start_y,
	input  wire logic signed [ogru_pkg::COORD_W-1:0]    end_x,
	input  wire logic signed [ogru_pkg::COORD_W-1:0]    end_y,
	output logic                                        status,
	output logic [7:0]                                  cell_value,
	output logic [ogru_pkg::TRACED_W-1:0]               cells_traced
);

	localparam int CELLS = MAP_WIDTH * MAP_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int XW    = $clog2(MAP_WIDTH);
	localparam int YW    = $clog2(MAP_HEIGHT);
	localparam int CW    = COUNT_BITS;
	localparam int PW    = CW + 8;
	localparam int WW    = ogru_pkg::WALK_W;
	localparam int EW    = ogru_pkg::ERR_W;
	localparam logic signed [WW-1:0] X_LIM = WW'(MAP_WIDTH);
	localparam logic signed [WW-1:0] Y_LIM = WW'(MAP_HEIGHT);
	localparam logic [CW-1:0] COUNT_MAX = '1;

	// Captured request.
	logic                                  kind_q;
	logic signed [ogru_pkg::COORD_W-1:0]   sx_q, sy_q, ex_q, ey_q;
	logic signed [WW-1:0]                  ex12, ey12;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			sx_q   <= start_x;
			sy_q   <= start_y;
			ex_q   <= end_x;
			ey_q   <= end_y;
		end
	end

	assign ex12 = {ex_q[ogru_pkg::COORD_W-1], ex_q};
	assign ey12 = {ey_q[ogru_pkg::COORD_W-1], ey_q};

	// Line setup: deltas, axis choice and direction.
	logic signed [WW-1:0]                  dx, dy, dm;
	logic [WW-1:0]                         adx, ady, adm;
	logic                                  steep, swap;
	logic signed [ogru_pkg::COORD_W-1:0]   a0, b0, a1, b1, ax0, ay0, ax1, ay1;
	logic                                  end_off;

	always_comb begin
		dx    = {ex_q[10], ex_q} - {sx_q[10], sx_q};
		dy    = {ey_q[10], ey_q} - {sy_q[10], sy_q};
		adx   = dx[WW-1] ? WW'(-dx) : dx;
		ady   = dy[WW-1] ? WW'(-dy) : dy;
		steep = ady > adx;
		a0    = steep ? sy_q : sx_q;
		b0    = steep ? sx_q : sy_q;
		a1    = steep ? ey_q : ex_q;
		b1    = steep ? ex_q : ey_q;
		swap  = a0 > a1;
		ax0   = swap ? a1 : a0;
		ay0   = swap ? b1 : b0;
		ax1   = swap ? a0 : a1;
		ay1   = swap ? b0 : b1;
		dm    = {ay1[10], ay1} - {ay0[10], ay0};
		adm   = dm[WW-1] ? WW'(-dm) : dm;
		end_off = !(!ex12[WW-1] && (ex12 < X_LIM) && !ey12[WW-1] && (ey12 < Y_LIM));
	end

	// Walker registers.
	logic signed [WW-1:0] major_q, minor_q, ax1_q;
	logic [WW-1:0]        dmaj_q, dmin_q;
	logic signed [EW-1:0] err_q;
	logic                 steep_q, neg_q;

	logic signed [WW-1:0] px, py, minor_n;
	logic signed [EW-1:0] err_a, err_n;
	logic                 take, px_on, at_end, step_valid, walk_done;

	always_comb begin
		px      = steep_q ? minor_q : major_q;
		py      = steep_q ? major_q : minor_q;
		err_a   = err_q + $signed({2'b00, dmin_q});
		take    = $signed({err_a, 1'b0}) >= $signed({3'b000, dmaj_q});
		err_n   = take ? (err_a - $signed({2'b00, dmaj_q})) : err_a;
		minor_n = take ? (neg_q ? minor_q - WW'(1) : minor_q + WW'(1)) : minor_q;
		px_on   = !px[WW-1] && (px < X_LIM) && !py[WW-1] && (py < Y_LIM);
		at_end  = (px == ex12) && (py == ey12);
		step_valid = cmd.step && px_on && !at_end;
		walk_done  = major_q > ax1_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			major_q <= {ax0[10], ax0};
			minor_q <= {ay0[10], ay0};
			ax1_q   <= {ax1[10], ax1};
			dmaj_q  <= WW'({ax1[10], ax1} - {ax0[10], ax0});
			dmin_q  <= adm;
			err_q   <= '0;
			steep_q <= steep;
			neg_q   <= !(ay0 < ay1);
		end else if (cmd.step) begin
			major_q <= major_q + WW'(1);
			minor_q <= minor_n;
			err_q   <= err_n;
		end
	end

	// Memory address: current walker cell or the end cell.
	logic signed [WW-1:0] cx, cy;
	logic [AW-1:0]        raddr;
	logic                 re;
	logic [ogru_pkg::OP_W-1:0] op_n;

	always_comb begin
		cx    = cmd.step ? px : ex12;
		cy    = cmd.step ? py : ey12;
		raddr = AW'(cy[YW-1:0]) * AW'(MAP_WIDTH) + AW'(cx[XW-1:0]);
		re    = step_valid || cmd.issue_hit || cmd.issue_read;
		if (step_valid) op_n = ogru_pkg::OP_FREE;
		else if (cmd.issue_hit) op_n = ogru_pkg::OP_HIT;
		else if (cmd.issue_read) op_n = ogru_pkg::OP_READ;
		else op_n = ogru_pkg::OP_NONE;
	end

	// Clearing pass counter.
	logic [AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clear) clr_q <= clr_q + AW'(1);
	end

	// Grid memories with registered read data.
	logic [7:0]      val_mem [CELLS];
	logic [2*CW-1:0] cnt_mem [CELLS];
	logic [7:0]      val_rd_s1;
	logic [2*CW-1:0] cnt_rd_s1;
	logic [ogru_pkg::OP_W-1:0] op_s1;
	logic [AW-1:0]   addr_s1;
	logic            val_we, cnt_we;
	logic [AW-1:0]   waddr;
	logic [7:0]      val_wd;
	logic [2*CW-1:0] cnt_wd;

	always_ff @(posedge clk) begin
		if (re) val_rd_s1 <= val_mem[raddr];
		if (val_we) val_mem[waddr] <= val_wd;
	end

	always_ff @(posedge clk) begin
		if (re) cnt_rd_s1 <= cnt_mem[raddr];
		if (cnt_we) cnt_mem[waddr] <= cnt_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) op_s1 <= ogru_pkg::OP_NONE;
		else op_s1 <= op_n;
	end

	always_ff @(posedge clk) begin
		if (re) addr_s1 <= raddr;
	end

	// Cell update on the returned data.
	logic [CW-1:0] hits, miss, hits_n, miss_n;
	logic [8:0]    floor_v, sum_v;
	logic [7:0]    free_v, hit_v;
	logic          is_upd, log_mode;

	always_comb begin
		hits     = cnt_rd_s1[2*CW-1:CW];
		miss     = cnt_rd_s1[CW-1:0];
		hits_n   = (hits == COUNT_MAX) ? hits : hits + CW'(1);
		miss_n   = (miss == COUNT_MAX) ? miss : miss + CW'(1);
		floor_v  = {1'b0, cfg.free_step} + {1'b0, cfg.value_min};
		free_v   = ({1'b0, val_rd_s1} < floor_v) ? cfg.value_min
			: val_rd_s1 - cfg.free_step;
		sum_v    = {1'b0, val_rd_s1} + {1'b0, cfg.occupied_step};
		hit_v    = (sum_v > {1'b0, cfg.value_max}) ? cfg.value_max : sum_v[7:0];
		is_upd   = (op_s1 == ogru_pkg::OP_FREE) || (op_s1 == ogru_pkg::OP_HIT);
		log_mode = (cfg.mode == ogru_pkg::MODE_LOG);
		val_we   = cmd.clear || (is_upd && log_mode);
		cnt_we   = cmd.clear || (is_upd && !log_mode);
		waddr    = cmd.clear ? clr_q : addr_s1;
		if (cmd.clear) val_wd = ogru_pkg::VALUE_UNKNOWN;
		else if (op_s1 == ogru_pkg::OP_FREE) val_wd = free_v;
		else val_wd = hit_v;
		if (cmd.clear) cnt_wd = '0;
		else if (op_s1 == ogru_pkg::OP_FREE) cnt_wd = {hits, miss_n};
		else cnt_wd = {hits_n, miss};
	end

	// Read evaluation: hit share against the threshold.
	logic [CW:0]   total;
	logic [PW-1:0] hext;
	logic          rd_s2, zero_s2, mode_s2;
	logic [PW-1:0] h100_s2, prod_s2;
	logic [7:0]    val_s2;

	assign total = {1'b0, hits} + {1'b0, miss};
	assign hext  = PW'(hits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_s2 <= 1'b0;
		else rd_s2 <= (op_s1 == ogru_pkg::OP_READ);
	end

	always_ff @(posedge clk) begin
		if (op_s1 == ogru_pkg::OP_READ) begin
			h100_s2 <= (hext << 6) + (hext << 5) + (hext << 2);
			prod_s2 <= PW'(cfg.occupied_percent) * PW'(total);
			zero_s2 <= (total == '0);
			mode_s2 <= cfg.mode;
			val_s2  <= val_rd_s1;
		end
	end

	// Result of the item under work.
	logic                           res_status_q;
	logic [7:0]                     res_value_q;
	logic [ogru_pkg::TRACED_W-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			res_status_q <= end_off;
			res_value_q  <= '0;
			count_q      <= '0;
		end else begin
			if (step_valid || cmd.issue_hit) count_q <= count_q + ogru_pkg::TRACED_W'(1);
			if (rd_s2) begin
				if (mode_s2 == ogru_pkg::MODE_LOG) res_value_q <= val_s2;
				else if (zero_s2) res_value_q <= ogru_pkg::VALUE_UNKNOWN;
				else if (h100_s2 > prod_s2) res_value_q <= ogru_pkg::VALUE_OCCUPIED;
				else res_value_q <= ogru_pkg::VALUE_FREE;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status       <= res_status_q;
			cell_value   <= res_value_q;
			cells_traced <= count_q;
		end
	end

	always_comb begin
		sts.clear_last = (clr_q == AW'(CELLS - 1));
		sts.end_off    = end_off;
		sts.is_read    = (kind_q == ogru_pkg::KIND_READ);
		sts.walk_done  = walk_done;
		sts.pipe_busy  = (op_s1 != ogru_pkg::OP_NONE) || rd_s2;
	end

endmodule
`default_nettype wire

[hw/rtl/occupancy_grid_ray_update.sv]
// Top level: configuration registers, controller and datapath.
// Usage: a request on req carries a kind, a sensor cell and an end cell. A ray
// (kind 0) walks the Bresenham line between sensor and hit cell and updates
// each traced in-map cell and then the hit cell; a read (kind 1) returns the
// occupancy value of the end cell. Each request gives one result on rsp.
// The user writes configuration on wr_en / wr_index / wr_data only while the
// block idles; the block itself does not enforce this. The walker visits one
// cell per cycle with one read-modify-write on the grid memory port. An end
// cell off the map returns status 1. One item is worked on at a time; the next
// request is taken once the result sits in the output register, so a stalled
// receiver holds at most one result and one finished item before req stops
// being taken. After reset a clearing pass writes every cell, during which req
// is not ready; configuration writes are taken always.
`default_nettype none
module occupancy_grid_ray_update #(
	parameter int MAP_WIDTH  = 256,
	parameter int MAP_HEIGHT = 256,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 wr_en,
	input  wire logic [ogru_pkg::CFG_IDX_W-1:0]       wr_index,
	input  wire logic [ogru_pkg::CFG_DATA_W-1:0]      wr_data,
	ogru_req_if.sink                                  req,
	ogru_rsp_if.source                                rsp
);

	ogru_pkg::cfg_t cfg_q;
	ogru_pkg::cmd_t cmd;
	ogru_pkg::sts_t sts;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ogru_pkg::CFG_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				ogru_pkg::REG_MODE:     cfg_q.mode             <= wr_data[0];
				ogru_pkg::REG_FREE:     cfg_q.free_step        <= wr_data;
				ogru_pkg::REG_OCCUPIED: cfg_q.occupied_step    <= wr_data;
				ogru_pkg::REG_MIN:      cfg_q.value_min        <= wr_data;
				ogru_pkg::REG_MAX:      cfg_q.value_max        <= wr_data;
				ogru_pkg::REG_PERCENT:  cfg_q.occupied_percent <= wr_data[6:0];
				default: ;
			endcase
		end
	end

	ogru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ogru_dp #(
		.MAP_WIDTH  (MAP_WIDTH),
		.MAP_HEIGHT (MAP_HEIGHT),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (req.kind),
		.start_x      (req.start_x),
		.start_y      (req.start_y),
		.end_x        (req.end_x),
		.end_y        (req.end_y),
		.status       (rsp.status),
		.cell_value   (rsp.cell_value),
		.cells_traced (rsp.cells_traced)
	);

endmodule
`default_nettype wire
